// File: hw/rtl/fftm_pkg.sv
`timescale 1ns / 1ps

package fftm_pkg;

    // default transform length
    localparam int unsigned POINTS_DEFAULT = 128;

    // field widths
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned WORK_W   = 21;
    localparam int unsigned PAIR_W   = 6;
    localparam int unsigned MAG_W    = 19;
    localparam int unsigned TW_W     = 16;

    // square root operand: sum of two squared work words
    localparam int unsigned SQ_W     = 2 * WORK_W;
    localparam int unsigned SQRT_STEPS = WORK_W;

endpackage

// File: hw/rtl/fftm_ram.sv
`timescale 1ns / 1ps

module fftm_ram #(
    parameter int unsigned WIDTH = 42,
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/fftm_fifo.sv
`timescale 1ns / 1ps

module fftm_fifo #(
    parameter int unsigned WIDTH = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("fifo push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("fifo pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("fifo count out of range");
`endif

endmodule

// File: hw/rtl/fftm_front.sv
`timescale 1ns / 1ps

module fftm_front
    import fftm_pkg::*;
#(
    parameter int unsigned POINTS = POINTS_DEFAULT,
    localparam int unsigned LOG = $clog2(POINTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                fifo_full,
    input  logic                frame_done,
    output logic                busy,
    output logic                push,
    output logic [LOG-1:0]      push_addr,
    output logic [SAMPLE_W-1:0] push_sample,
    output logic                push_last
);

    logic [LOG-1:0] count_reg, count_next;
    logic           hold_reg, hold_next;
    logic           last;

    assign busy = fifo_full || hold_reg;
    assign push = start && !busy;
    assign last = (count_reg == LOG'(POINTS - 1));

    // bit-reversed store position of this sample
    always_comb
    begin
        for (int i = 0; i < LOG; i++)
        begin
            push_addr[i] = count_reg[LOG-1-i];
        end
    end

    assign push_sample = sample;
    assign push_last   = last;

    // frame counter; hold off after the last sample until the back end drains
    always_comb
    begin
        count_next = count_reg;
        hold_next  = hold_reg;
        if (push)
        begin
            count_next = last ? '0 : count_reg + 1'b1;
            if (last)
            begin
                hold_next = 1'b1;
            end
        end
        if (frame_done)
        begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

// File: hw/rtl/fftm_back.sv
`timescale 1ns / 1ps

module fftm_back
    import fftm_pkg::*;
#(
    parameter int unsigned POINTS = POINTS_DEFAULT,
    localparam int unsigned LOG = $clog2(POINTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_empty,
    input  logic [LOG-1:0]      item_addr,
    input  logic [SAMPLE_W-1:0] item_sample,
    input  logic                item_last,
    output logic                pop,
    output logic                frame_done,
    output logic                result_strobe,
    output logic [PAIR_W-1:0]   pair_index,
    output logic [MAG_W-1:0]    magnitude_even,
    output logic [MAG_W-1:0]    magnitude_odd,
    output logic                last_pair
);

    localparam int unsigned Quarter = POINTS / 4;
    localparam int unsigned RomW    = $clog2(Quarter + 1);
    localparam int unsigned StW     = $clog2(LOG);
    localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

    // quarter-wave sine, Q30 Taylor series rounded to Q15
    function automatic logic [16:0] qsin_f(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic signed [63:0] s;
        logic [63:0] q;
        x  = HalfPiQ30 * 64'(idx) / Quarter;
        x2 = (x * x) >> 30;
        t  = x;
        s  = signed'(x);
        for (int n = 1; n <= 12; n++)
        begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                s = s - signed'(t);
            end
            else
            begin
                s = s + signed'(t);
            end
        end
        if (s < 0)
        begin
            s = 0;
        end
        q = (unsigned'(s) + 64'd16384) >> 15;
        if (q > 64'd32768)
        begin
            q = 64'd32768;
        end
        return q[16:0];
    endfunction

    logic [16:0] qsin_rom [Quarter + 1];
    for (genvar g = 0; g <= Quarter; g++)
    begin : g_rom
        assign qsin_rom[g] = qsin_f(g);
    end

    typedef enum logic [4:0] {
        ST_IDLE, ST_RA, ST_RB, ST_LB, ST_M1, ST_M2, ST_M3, ST_M4, ST_WA, ST_WB,
        ST_ORD, ST_OWAIT, ST_OLD, ST_SQ1, ST_SQ2, ST_SQRT, ST_EMIT
    } state_t;

    state_t state_reg;

    logic [StW-1:0]     stage_reg;
    logic [LOG-2:0]     bf_reg;
    logic [LOG-2:0]     k_reg;
    logic               odd_reg;
    logic               twf_reg;
    logic signed [WORK_W-1:0] a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic signed [TW_W-1:0]   wr_reg, wi_reg;
    logic signed [SQ_W-1:0]   acc_reg, acc2_reg;
    logic [SQ_W-1:0]    rem_reg, root_reg, bit_reg;
    logic [4:0]         step_reg;
    logic [MAG_W-1:0]   even_reg, mag_even_reg, mag_odd_reg;
    logic               strobe_reg, last_reg, done_reg;
    logic [PAIR_W-1:0]  pair_reg;

    // butterfly addressing
    logic [LOG-1:0] half, jj, addr_a, addr_b;
    logic [LOG-2:0] tw;
    logic [LOG-1:0] c_idx, s_idx;
    logic           tw_hi;
    logic [16:0]    c_mag, s_mag;
    logic signed [17:0] c_val, s_val;
    logic signed [TW_W-1:0] wr_calc, wi_calc;

    always_comb
    begin
        half   = LOG'(1) << stage_reg;
        jj     = {1'b0, bf_reg} & (half - 1'b1);
        addr_a = ((({1'b0, bf_reg}) >> stage_reg) << (stage_reg + 1'b1)) | jj;
        addr_b = addr_a | half;
        tw     = jj[LOG-2:0] << (StW'(LOG - 1) - stage_reg);
        tw_hi  = ({1'b0, tw} > LOG'(Quarter));
        c_idx  = tw_hi ? ({1'b0, tw} - LOG'(Quarter)) : (LOG'(Quarter) - {1'b0, tw});
        s_idx  = tw_hi ? (LOG'(2 * Quarter) - {1'b0, tw}) : {1'b0, tw};
        c_mag  = qsin_rom[c_idx[RomW-1:0]];
        s_mag  = qsin_rom[s_idx[RomW-1:0]];
        c_val  = tw_hi ? -signed'({1'b0, c_mag}) : signed'({1'b0, c_mag});
        s_val  = signed'({1'b0, s_mag});
        // cosine of +1.0 saturates
        wr_calc = (c_val > 18'sd32767) ? 16'sd32767 : c_val[TW_W-1:0];
        wi_calc = 16'(-s_val);
    end

    // shared multiplier
    logic signed [WORK_W-1:0] mul_x, mul_y;
    logic signed [SQ_W-1:0]   prod;

    always_comb
    begin
        case (state_reg)
            ST_M1:   begin mul_x = b_re_reg; mul_y = WORK_W'(wr_reg); end
            ST_M2:   begin mul_x = b_im_reg; mul_y = WORK_W'(wi_reg); end
            ST_M3:   begin mul_x = b_re_reg; mul_y = WORK_W'(wi_reg); end
            ST_M4:   begin mul_x = b_im_reg; mul_y = WORK_W'(wr_reg); end
            ST_SQ2:  begin mul_x = a_im_reg; mul_y = a_im_reg; end
            default: begin mul_x = a_re_reg; mul_y = a_re_reg; end
        endcase
        prod = mul_x * mul_y;
    end

    // Q15 rounding of the twiddle products, or the raw b operand when the twiddle is one
    logic signed [SQ_W-1:0]   rnd_re, rnd_im;
    logic signed [WORK_W-1:0] p_re, p_im;

    always_comb
    begin
        rnd_re = acc_reg + SQ_W'(16384);
        rnd_im = acc2_reg + SQ_W'(16384);
        p_re   = twf_reg ? rnd_re[WORK_W+14:15] : b_re_reg;
        p_im   = twf_reg ? rnd_im[WORK_W+14:15] : b_im_reg;
    end

    // work store, real part high, imaginary part low
    logic                   ram_we;
    logic [LOG-1:0]         ram_waddr, ram_raddr;
    logic [2*WORK_W-1:0]    ram_wdata, ram_rdata;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = item_addr;
        ram_wdata = {WORK_W'(item_sample), WORK_W'(0)};
        ram_raddr = addr_a;
        case (state_reg)
            ST_IDLE:
            begin
                ram_we = !fifo_empty;
            end
            ST_RB, ST_LB:
            begin
                ram_raddr = addr_b;
            end
            ST_WA:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_a;
                ram_wdata = {a_re_reg + p_re, a_im_reg + p_im};
            end
            ST_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_b;
                ram_wdata = {a_re_reg - p_re, a_im_reg - p_im};
            end
            ST_ORD, ST_OWAIT, ST_OLD:
            begin
                ram_raddr = {k_reg, odd_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign pop = (state_reg == ST_IDLE) && !fifo_empty;

    fftm_ram #(
        .WIDTH(2 * WORK_W),
        .DEPTH(POINTS)
    ) u_work (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // square root trial
    logic [SQ_W-1:0] trial;
    logic [MAG_W-1:0] mag_sat;
    assign trial   = root_reg + bit_reg;
    assign mag_sat = (root_reg > SQ_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : root_reg[MAG_W-1:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stage_reg  <= '0;
            bf_reg     <= '0;
            k_reg      <= '0;
            odd_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            done_reg   <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    stage_reg <= '0;
                    bf_reg    <= '0;
                    if (!fifo_empty && item_last)
                    begin
                        state_reg <= ST_RA;
                    end
                end
                ST_RA:
                begin
                    state_reg <= ST_RB;
                end
                ST_RB:
                begin
                    a_re_reg  <= ram_rdata[2*WORK_W-1:WORK_W];
                    a_im_reg  <= ram_rdata[WORK_W-1:0];
                    state_reg <= ST_LB;
                end
                ST_LB:
                begin
                    b_re_reg  <= ram_rdata[2*WORK_W-1:WORK_W];
                    b_im_reg  <= ram_rdata[WORK_W-1:0];
                    wr_reg    <= wr_calc;
                    wi_reg    <= wi_calc;
                    twf_reg   <= (jj != '0);
                    state_reg <= (jj != '0) ? ST_M1 : ST_WA;
                end
                ST_M1:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    acc_reg   <= acc_reg - prod;
                    state_reg <= ST_M3;
                end
                ST_M3:
                begin
                    acc2_reg  <= prod;
                    state_reg <= ST_M4;
                end
                ST_M4:
                begin
                    acc2_reg  <= acc2_reg + prod;
                    state_reg <= ST_WA;
                end
                ST_WA:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    bf_reg <= bf_reg + 1'b1;
                    if (bf_reg == '1)
                    begin
                        if (stage_reg == StW'(LOG - 1))
                        begin
                            k_reg     <= '0;
                            odd_reg   <= 1'b0;
                            state_reg <= ST_ORD;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= ST_RA;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_RA;
                    end
                end
                ST_ORD:
                begin
                    state_reg <= ST_OWAIT;
                end
                ST_OWAIT:
                begin
                    state_reg <= ST_OLD;
                end
                ST_OLD:
                begin
                    a_re_reg  <= ram_rdata[2*WORK_W-1:WORK_W];
                    a_im_reg  <= ram_rdata[WORK_W-1:0];
                    state_reg <= ST_SQ1;
                end
                ST_SQ1:
                begin
                    rem_reg   <= unsigned'(prod);
                    state_reg <= ST_SQ2;
                end
                ST_SQ2:
                begin
                    rem_reg   <= rem_reg + unsigned'(prod);
                    root_reg  <= '0;
                    bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                    step_reg  <= 5'(SQRT_STEPS - 1);
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!odd_reg)
                    begin
                        even_reg  <= mag_sat;
                        odd_reg   <= 1'b1;
                        state_reg <= ST_ORD;
                    end
                    else
                    begin
                        mag_even_reg <= even_reg;
                        mag_odd_reg  <= mag_sat;
                        pair_reg     <= PAIR_W'(k_reg);
                        last_reg     <= (k_reg == '1);
                        strobe_reg   <= 1'b1;
                        odd_reg      <= 1'b0;
                        k_reg        <= k_reg + 1'b1;
                        if (k_reg == '1)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_strobe  = strobe_reg;
    assign pair_index     = pair_reg;
    assign magnitude_even = mag_even_reg;
    assign magnitude_odd  = mag_odd_reg;
    assign last_pair      = last_reg && strobe_reg;
    assign frame_done     = done_reg;

`ifndef NO_ASSERTIONS
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |=> !strobe_reg)
        else $error("result strobe held longer than one cycle");
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> strobe_reg && last_reg)
        else $error("frame end without final pair");
    a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("sample taken during transform");
`endif

endmodule

// File: hw/rtl/fft_magnitude_128_unit.sv
`timescale 1ns / 1ps

// Channel    Handshake                Payload
// ---------  -----------------------  ----------------------------------------------
// sample in  start & !busy            sample
// result     result_strobe (1 cycle)  pair_index, magnitude_even, magnitude_odd,
//                                     last_pair
//
// Each sample is one transfer; a sample that does not end a frame is stored
// through a two-entry queue. The final sample of a frame starts the
// transform: butterflies run through the work store (one write port, one
// registered read port), skipping the multiply steps when the twiddle is
// one, then each bin gets squares and a one-bit-per-cycle square root.
// busy stays high from the last sample until the final pair is sent.
// Reset clears counters and the sequencer; the work store needs no clearing.
// The receiver cannot stall: each result is valid for exactly one cycle.

module fft_magnitude_128_unit
    import fftm_pkg::*;
#(
    parameter int unsigned POINTS = POINTS_DEFAULT,
    localparam int unsigned LOG = $clog2(POINTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                result_strobe,
    output logic [PAIR_W-1:0]   pair_index,
    output logic [MAG_W-1:0]    magnitude_even,
    output logic [MAG_W-1:0]    magnitude_odd,
    output logic                last_pair
);

    localparam int unsigned ItemW = LOG + SAMPLE_W + 1;

    logic                push, pop, fifo_full, fifo_empty, frame_done;
    logic [LOG-1:0]      push_addr, item_addr;
    logic [SAMPLE_W-1:0] push_sample, item_sample;
    logic                push_last, item_last;
    logic [ItemW-1:0]    item_data;

    // sample intake and store ordering
    fftm_front #(
        .POINTS(POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .sample     (sample),
        .fifo_full  (fifo_full),
        .frame_done (frame_done),
        .busy       (busy),
        .push       (push),
        .push_addr  (push_addr),
        .push_sample(push_sample),
        .push_last  (push_last)
    );

    // queue between intake and transform engine
    fftm_fifo #(
        .WIDTH(ItemW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data({push_addr, push_sample, push_last}),
        .pop      (pop),
        .pop_data (item_data),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    assign {item_addr, item_sample, item_last} = item_data;

    // transform and magnitude engine
    fftm_back #(
        .POINTS(POINTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (fifo_empty),
        .item_addr     (item_addr),
        .item_sample   (item_sample),
        .item_last     (item_last),
        .pop           (pop),
        .frame_done    (frame_done),
        .result_strobe (result_strobe),
        .pair_index    (pair_index),
        .magnitude_even(magnitude_even),
        .magnitude_odd (magnitude_odd),
        .last_pair     (last_pair)
    );

endmodule

// File: bench/tb_fft_magnitude_128_unit.sv
`timescale 1ns / 1ps

module tb_fft_magnitude_128_unit;
    import fftm_pkg::*;

    localparam int unsigned NPTS = POINTS_DEFAULT;
    localparam int unsigned QTR = NPTS / 4;
    localparam int unsigned NLOG = $clog2(NPTS);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned MAG_SAT = 64'd524287;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [PAIR_W-1:0] pair;
        logic [MAG_W-1:0]  mag_even;
        logic [MAG_W-1:0]  mag_odd;
        logic              last;
    } bin_pair_t;

    // spectrum predictor and queue of pending bin pairs
    class spectrum_scoreboard;
        longint   sin_rom[QTR+1];
        longint   buf_re[NPTS];
        longint   buf_im[NPTS];
        int       fill;
        int       mismatches;
        bin_pair_t pending[$];

        function new();
            longint unsigned x, x2, t;
            longint s, q;
            fill = 0;
            mismatches = 0;
            // quarter-wave sine table from a fixed-point Taylor series
            for (int i = 0; i <= QTR; i++)
            begin
                x = HALF_PI_Q30 * longint'(i) / longint'(QTR);
                x2 = (x * x) >> 30;
                t = x;
                s = longint'(x);
                for (int n = 1; n <= 12; n++)
                begin
                    t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        s = s - longint'(t);
                    else
                        s = s + longint'(t);
                end
                if (s < 0)
                    s = 0;
                q = longint'((longint'(s) + 16384) >>> 15);
                if (q > 32768)
                    q = 32768;
                sin_rom[i] = q;
            end
        endfunction

        function automatic longint wrap21(longint v);
            logic [WORK_W-1:0] w;
            w = v[WORK_W-1:0];
            return longint'($signed(w));
        endfunction

        function automatic longint unsigned root_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic logic [MAG_W-1:0] bin_mag(int i);
            longint ar, ai;
            longint unsigned m;
            ar = buf_re[i] < 0 ? -buf_re[i] : buf_re[i];
            ai = buf_im[i] < 0 ? -buf_im[i] : buf_im[i];
            m = root_floor(longint'(ar * ar + ai * ai));
            if (m > MAG_SAT)
                m = MAG_SAT;
            return m[MAG_W-1:0];
        endfunction

        function void transform();
            longint wr, wi, c, s, pr, pi, br, bi;
            int a, b, tw;
            for (int len = 2; len <= NPTS; len = len * 2)
            begin
                for (int base = 0; base < NPTS; base += len)
                begin
                    for (int j = 0; j < len / 2; j++)
                    begin
                        a = base + j;
                        b = a + len / 2;
                        br = buf_re[b];
                        bi = buf_im[b];
                        if (j == 0)
                        begin
                            pr = br;
                            pi = bi;
                        end
                        else
                        begin
                            tw = (j * (NPTS / len)) % (2 * QTR);
                            if (tw <= QTR)
                            begin
                                c = sin_rom[QTR - tw];
                                s = sin_rom[tw];
                            end
                            else
                            begin
                                c = -sin_rom[tw - QTR];
                                s = sin_rom[2 * QTR - tw];
                            end
                            if (c > 32767)
                                c = 32767;
                            wr = c;
                            wi = -s;
                            pr = (br * wr - bi * wi + 16384) >>> 15;
                            pi = (br * wi + bi * wr + 16384) >>> 15;
                        end
                        buf_re[b] = wrap21(buf_re[a] - pr);
                        buf_im[b] = wrap21(buf_im[a] - pi);
                        buf_re[a] = wrap21(buf_re[a] + pr);
                        buf_im[a] = wrap21(buf_im[a] + pi);
                    end
                end
            end
        endfunction

        // accepted sample transfer
        function void note_sample(logic [SAMPLE_W-1:0] smp);
            logic [NLOG-1:0] idx, rev;
            bin_pair_t bp;
            idx = fill[NLOG-1:0];
            for (int i = 0; i < NLOG; i++)
                rev[i] = idx[NLOG-1-i];
            buf_re[rev] = longint'(smp);
            buf_im[rev] = 0;
            fill++;
            if (fill < NPTS)
                return;
            fill = 0;
            transform();
            for (int k = 0; k < NPTS / 2; k++)
            begin
                bp.pair = k[PAIR_W-1:0];
                bp.mag_even = bin_mag(2 * k);
                bp.mag_odd = bin_mag(2 * k + 1);
                bp.last = (k == NPTS / 2 - 1);
                pending.push_back(bp);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // accepted result transfer
        task check_pair(bin_pair_t got);
            bin_pair_t exp_p;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result pair %0d", got.pair));
                return;
            end
            exp_p = pending.pop_front();
            if (got.pair !== exp_p.pair)
                report($sformatf("pair_index %0d, want %0d", got.pair, exp_p.pair));
            if (got.mag_even !== exp_p.mag_even)
                report($sformatf("pair %0d magnitude_even %0d, want %0d",
                                 exp_p.pair, got.mag_even, exp_p.mag_even));
            if (got.mag_odd !== exp_p.mag_odd)
                report($sformatf("pair %0d magnitude_odd %0d, want %0d",
                                 exp_p.pair, got.mag_odd, exp_p.mag_odd));
            if (got.last !== exp_p.last)
                report($sformatf("pair %0d last_pair %0b, want %0b",
                                 exp_p.pair, got.last, exp_p.last));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [SAMPLE_W-1:0] sample;
    logic                result_strobe;
    logic [PAIR_W-1:0]   pair_index;
    logic [MAG_W-1:0]    magnitude_even;
    logic [MAG_W-1:0]    magnitude_odd;
    logic                last_pair;

    spectrum_scoreboard sb;
    int cycle_count;
    int burst_left;

    fft_magnitude_128_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample         (sample),
        .result_strobe  (result_strobe),
        .pair_index     (pair_index),
        .magnitude_even (magnitude_even),
        .magnitude_odd  (magnitude_odd),
        .last_pair      (last_pair)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_fft_magnitude_128_unit failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        bin_pair_t got;
        if (rst_n && result_strobe)
        begin
            got.pair = pair_index;
            got.mag_even = magnitude_even;
            got.mag_odd = magnitude_odd;
            got.last = last_pair;
            sb.check_pair(got);
        end
    end

    // one sample transfer, with bursts and random gaps
    task automatic send_sample(logic [SAMPLE_W-1:0] v);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        start <= 1'b1;
        sample <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_sample(v);
        burst_left--;
    endtask

    task automatic send_frame(int kind);
        logic [SAMPLE_W-1:0] v;
        int amp;
        amp = $urandom_range(0, 3);
        for (int i = 0; i < NPTS; i++)
        begin
            case (kind)
                0: v = '1;
                1: v = (i % 2) ? '1 : '0;
                2: v = (i == 0) ? '1 : '0;
                3: v = $urandom_range(0, 4095);
                default: v = (amp == 0) ? $urandom_range(0, 15)
                           : ((i * amp) % 8 < 4 ? 12'hfff - $urandom_range(0, 63)
                                                : $urandom_range(0, 63));
            endcase
            send_sample(v);
        end
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full scale, Nyquist square wave, impulse
        send_frame(0);
        send_frame(1);
        send_frame(2);

        // hold off until the spectrum drains
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        @(posedge clk);

        for (int f = 0; f < 1; f++)
            send_frame($urandom_range(3, 4));
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_fft_magnitude_128_unit passed");
        else
            $display("tb_fft_magnitude_128_unit failed");
        $finish;
    end

endmodule
